// ===== design/sbdf_pkg.sv =====
// Shared types and constants for the square box duplicate filter.
// Holds the fixed field widths, reset values, verdict codes and register indexes.
// Depends on nothing; imported by square_box_duplicate_filter_core.
`timescale 1ns / 1ps
`default_nettype none

package sbdf_pkg;

  // Width of the size fields and of the image size registers.
  localparam int unsigned SIZE_W = 13;
  // Width of an area, the product of two sizes.
  localparam int unsigned AREA_W = 2 * SIZE_W;
  // Width of the register index on the configuration port.
  localparam int unsigned CFG_IDX_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'b1;

  // Reset values of the image size registers.
  localparam logic [SIZE_W-1:0] ROWS_RESET = 13'd480;
  localparam logic [SIZE_W-1:0] COLS_RESET = 13'd640;

  // Outcome of one box.
  typedef enum logic [1:0] {
    VERDICT_NEW  = 2'd0,
    VERDICT_DUP  = 2'd1,
    VERDICT_FULL = 2'd2
  } verdict_e;

endpackage

`default_nettype wire

// ===== design/square_box_duplicate_filter_core.sv =====
// Square box duplicate filter: squares a candidate box and checks it against a box table.
// Holds the sequencer, the shared overlap compare pipeline and the table memory.
// Depends on sbdf_pkg.
//
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one candidate box per transfer.
//   Output channel (out_valid_o / out_stall_i) carries one result per box: the
//   verdict, the squared box and the number of stored boxes after this box.
//   Configuration (cfg_valid_i / cfg_ready_o) writes image_rows (index 0) and image_cols
//   (index 1) in any cycle; write only while idle, which the block does not enforce.
// Scan
//   With N stored boxes to compare against (at most TABLE_DEPTH), the single compare
//   pipeline reads one table entry a cycle, then drains before the verdict is formed.
//   The next box is not taken until the result of the last one is loaded into the
//   output register.
// Reset
//   Empties the table and restores image_rows = 480 and image_cols = 640. The
//   table memory itself is not cleared: only entries below the fill count are read.
// Stalls
//   A result waits in the output register while out_stall_i is high. The next box
//   may be taken meanwhile; it then waits in its final step until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module square_box_duplicate_filter_core #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned COORD_BITS  = 12
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write channel
  input  wire logic                                 cfg_valid_i,
  output      logic                                 cfg_ready_o,
  input  wire logic [sbdf_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [sbdf_pkg::SIZE_W-1:0]          cfg_data_i,
  // Input channel
  input  wire logic                                 in_valid_i,
  output      logic                                 in_stall_o,
  input  wire logic                                 new_frame_i,
  input  wire logic [COORD_BITS-1:0]                box_x_i,
  input  wire logic [COORD_BITS-1:0]                box_y_i,
  input  wire logic [sbdf_pkg::SIZE_W-1:0]          box_w_i,
  input  wire logic [sbdf_pkg::SIZE_W-1:0]          box_h_i,
  // Output channel
  output      logic                                 out_valid_o,
  input  wire logic                                 out_stall_i,
  output      logic [1:0]                           verdict_o,
  output      logic [COORD_BITS-1:0]                out_x_o,
  output      logic [COORD_BITS-1:0]                out_y_o,
  output      logic [sbdf_pkg::SIZE_W-1:0]          out_w_o,
  output      logic [sbdf_pkg::SIZE_W-1:0]          out_h_o,
  output      logic [$clog2(TABLE_DEPTH+1)-1:0]     stored_count_o
);

  import sbdf_pkg::*;

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned SW   = SIZE_W;
  localparam int unsigned AW   = AREA_W;
  localparam int unsigned EW   = ((CW > SW) ? CW : SW) + 2;
  localparam int unsigned CNTW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // One table entry: the squared box and its area.
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [SW-1:0] w;
    logic [SW-1:0] h;
    logic [AW-1:0] area;
  } entry_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQ1    = 6'b000010,
    ST_SQ2    = 6'b000100,
    ST_AREA   = 6'b001000,
    ST_SCAN   = 6'b010000,
    ST_DECIDE = 6'b100000
  } state_e;

  // Control state
  state_e          state_q, state_d;
  logic [CNTW-1:0] count_q, count_d;
  logic [CNTW-1:0] scan_idx_q, scan_idx_d;
  logic            dup_q, dup_d;
  logic            out_valid_q, out_valid_d;
  logic            v1_q, v2_q, v3_q;
  logic [SW-1:0]   rows_q, cols_q;

  // Sequencer strobes
  logic     in_take;
  logic     issue;
  logic     mem_we;
  logic     out_load;
  verdict_e verdict_d;

  // Input box
  logic [CW-1:0] bx_q, by_q;
  logic [SW-1:0] bw_q, bh_q;

  // Squaring step one
  logic              wide;
  logic [SW-1:0]     diff;
  logic [SW-1:0]     half;
  logic [CW-1:0]     pos;
  logic signed [EW:0] shifted;
  logic              wide_q;
  logic [CW-1:0]     npos_q;
  logic [SW-1:0]     grow_q;

  // Squaring step two
  logic [SW-1:0]      limit;
  logic [EW-1:0]      reach;
  logic signed [EW:0] room;
  logic [SW-1:0]      side;
  logic [CW-1:0]      cx_q, cy_q;
  logic [SW-1:0]      cw_q, ch_q;
  logic [AW-1:0]      ac_q;

  // Table memory and compare pipeline
  entry_t             table_mem [TABLE_DEPTH];
  entry_t             rd_q;
  entry_t             wr_entry;
  logic [EW-1:0]      a_end_x, s_end_x, a_end_y, s_end_y;
  logic [EW-1:0]      min_end_x, min_end_y;
  logic [CW-1:0]      max_x, max_y;
  logic signed [EW:0] dxs, dys;
  logic [SW-1:0]      dx, dy;
  logic [AW-1:0]      lo, hi;
  logic [AW+1:0]      lo3;
  logic [SW-1:0]      dx_q, dy_q;
  logic [AW+1:0]      lo3_q, lo3b_q;
  logic               hiok_q, nz_q, okb_q;
  logic [AW-1:0]      ov_q;
  logic               hit;

  // Output register
  verdict_e        verdict_q;
  logic [CW-1:0]   ox_q, oy_q;
  logic [SW-1:0]   ow_q, oh_q;
  logic [CNTW-1:0] ocount_q;

  // Configuration registers are written whenever a transfer arrives.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IMAGE_ROWS: rows_q <= cfg_data_i;
        CFG_IMAGE_COLS: cols_q <= cfg_data_i;
      endcase
    end
  end

  // Sequencer.
  assign in_stall_o = (state_q != ST_IDLE);
  assign hit        = okb_q && ({ov_q, 2'b00} > lo3b_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_idx_d  = scan_idx_q;
    dup_d       = dup_q;
    out_valid_d = out_valid_q;
    in_take     = 1'b0;
    issue       = 1'b0;
    mem_we      = 1'b0;
    out_load    = 1'b0;
    verdict_d   = VERDICT_NEW;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_take = 1'b1;
          if (new_frame_i) begin
            count_d = '0;
          end
          state_d = ST_SQ1;
        end
      end
      ST_SQ1: begin
        state_d = ST_SQ2;
      end
      ST_SQ2: begin
        state_d = ST_AREA;
      end
      ST_AREA: begin
        scan_idx_d = '0;
        dup_d      = 1'b0;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_idx_q < count_q) begin
          issue      = 1'b1;
          scan_idx_d = scan_idx_q + CNTW'(1);
        end else if (!v1_q && !v2_q && !v3_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (dup_q && (ac_q != '0)) begin
            verdict_d = VERDICT_DUP;
          end else if (count_q < CNTW'(TABLE_DEPTH)) begin
            verdict_d = VERDICT_NEW;
            mem_we    = 1'b1;
            count_d   = count_q + CNTW'(1);
          end else begin
            verdict_d = VERDICT_FULL;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Any stored box that passes both tests marks the candidate a duplicate.
    if (v3_q && hit) begin
      dup_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_idx_q  <= '0;
      dup_q       <= 1'b0;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      dup_q       <= dup_d;
      out_valid_q <= out_valid_d;
      v1_q        <= issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
    end
  end

  // Squaring, first step: shift the short side back by half the difference.
  assign wide    = (bw_q > bh_q);
  assign diff    = wide ? (bw_q - bh_q) : (bh_q - bw_q);
  assign half    = diff >> 1;
  assign pos     = wide ? by_q : bx_q;
  assign shifted = $signed({1'b0, EW'(pos)}) - $signed({1'b0, EW'(half)});

  // Squaring, second step: grow the short side and clip it at the image edge.
  assign limit = wide_q ? rows_q : cols_q;
  assign reach = EW'(npos_q) + EW'(grow_q);
  assign room  = $signed({1'b0, EW'(limit)}) - $signed({1'b0, EW'(npos_q)})
                 - $signed((EW + 1)'(1));

  always_comb begin
    if (reach >= EW'(limit)) begin
      side = room[EW] ? '0 : room[SW-1:0];
    end else begin
      side = grow_q;
    end
  end

  // Box datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      bx_q <= box_x_i;
      by_q <= box_y_i;
      bw_q <= box_w_i;
      bh_q <= box_h_i;
    end
    if (state_q == ST_SQ1) begin
      wide_q <= wide;
      npos_q <= shifted[EW] ? '0 : shifted[CW-1:0];
      grow_q <= wide ? bw_q : bh_q;
    end
    if (state_q == ST_SQ2) begin
      if (wide_q) begin
        cx_q <= bx_q;
        cy_q <= npos_q;
        cw_q <= bw_q;
        ch_q <= side;
      end else begin
        cx_q <= npos_q;
        cy_q <= by_q;
        cw_q <= side;
        ch_q <= bh_q;
      end
    end
    if (state_q == ST_AREA) begin
      ac_q <= cw_q * ch_q;
    end
  end

  // Table memory: one write port, one registered read port.
  assign wr_entry = '{x: cx_q, y: cy_q, w: cw_q, h: ch_q, area: ac_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[count_q[IW-1:0]] <= wr_entry;
    end
    rd_q <= table_mem[scan_idx_q[IW-1:0]];
  end

  // Compare stage: overlap extents and the area ratio test.
  assign a_end_x   = EW'(cx_q) + EW'(cw_q);
  assign s_end_x   = EW'(rd_q.x) + EW'(rd_q.w);
  assign a_end_y   = EW'(cy_q) + EW'(ch_q);
  assign s_end_y   = EW'(rd_q.y) + EW'(rd_q.h);
  assign min_end_x = (a_end_x < s_end_x) ? a_end_x : s_end_x;
  assign min_end_y = (a_end_y < s_end_y) ? a_end_y : s_end_y;
  assign max_x     = (cx_q > rd_q.x) ? cx_q : rd_q.x;
  assign max_y     = (cy_q > rd_q.y) ? cy_q : rd_q.y;
  assign dxs       = $signed({1'b0, min_end_x}) - $signed({1'b0, EW'(max_x)});
  assign dys       = $signed({1'b0, min_end_y}) - $signed({1'b0, EW'(max_y)});
  // A positive extent never exceeds the narrower box, so it fits a size field.
  assign dx        = dxs[EW] ? '0 : dxs[SW-1:0];
  assign dy        = dys[EW] ? '0 : dys[SW-1:0];
  assign lo        = (ac_q < rd_q.area) ? ac_q : rd_q.area;
  assign hi        = (ac_q < rd_q.area) ? rd_q.area : ac_q;
  assign lo3       = {2'b00, lo} + {1'b0, lo, 1'b0};

  always_ff @(posedge clk_i) begin
    dx_q   <= dx;
    dy_q   <= dy;
    lo3_q  <= lo3;
    hiok_q <= ({1'b0, hi} < {lo, 1'b0});
    nz_q   <= (rd_q.area != '0);
    // Overlap area stage.
    ov_q   <= dx_q * dy_q;
    lo3b_q <= lo3_q;
    okb_q  <= nz_q && hiok_q;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      verdict_q <= verdict_d;
      ox_q      <= cx_q;
      oy_q      <= cy_q;
      ow_q      <= cw_q;
      oh_q      <= ch_q;
      ocount_q  <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_o      = verdict_q;
  assign out_x_o        = ox_q;
  assign out_y_o        = oy_q;
  assign out_w_o        = ow_q;
  assign out_h_o        = oh_q;
  assign stored_count_o = ocount_q;

`ifndef SYNTHESIS
  // The fill count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  // The compare pipeline is empty once the verdict is formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE) |-> (!v1_q && !v2_q && !v3_q))
    else $error("compare pipeline not drained at verdict");

  // Storing a box grows the table by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (verdict_d == VERDICT_NEW)) |=> (count_q == $past(count_q) + CNTW'(1)))
    else $error("stored box did not grow the table by one");

  // A box is reported dropped only when the table is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (verdict_o == VERDICT_FULL)) |-> (stored_count_o == CNTW'(TABLE_DEPTH)))
    else $error("box dropped with room left in the table");

  // Table reads during a scan stay below the fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (scan_idx_q < count_q))
    else $error("table read beyond the stored boxes");
`endif

endmodule

`default_nettype wire
